FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCI_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define LCI_ASSERT_NR(name, prop, clk) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LCI_ASSERT(name, prop, clk, rst_n)
`define LCI_ASSERT_NR(name, prop, clk)
`endif
`endif

FILE: sv/lci_pkg.sv
`default_nettype none
package lci_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ROT_BITS      = 16;

  localparam int unsigned SQ_W        = 128;
  localparam int unsigned RT_W        = 64;
  localparam int unsigned SQRT_STAGES = RT_W;

  localparam int unsigned Q_W        = 63;
  localparam int unsigned DEN_W      = 65;
  localparam int unsigned DIV_STAGES = Q_W + 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_ROT  = 3'd0,
    CFG_SIN_ROT  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_CENTER_Z = 3'd4,
    CFG_RADIUS   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic               hit_valid;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/lci_sqrt.sv
`default_nettype none
module lci_sqrt import lci_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [SQ_W-1:0] x_i,
  output logic            valid_o,
  output logic [RT_W-1:0] root_o
);

  logic [SQRT_STAGES-1:0] v_q;
  logic [SQ_W-1:0]        x_q [SQRT_STAGES];
  logic [SQ_W-1:0]        r_q [SQRT_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[SQRT_STAGES-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (SQ_W - 2 - 2 * i);
    logic [SQ_W-1:0] x_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] t;
    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign r_in = r_q[i-1];
    end
    assign t = r_in + Bit;
    always_ff @(posedge clk_i) begin
      if (x_in >= t) begin
        x_q[i] <= x_in - t;
        r_q[i] <= (r_in >> 1) + Bit;
      end else begin
        x_q[i] <= x_in;
        r_q[i] <= r_in >> 1;
      end
    end
  end

  assign valid_o = v_q[SQRT_STAGES-1];
  assign root_o  = r_q[SQRT_STAGES-1][RT_W-1:0];

endmodule
`default_nettype wire

FILE: sv/lci_div.sv
`default_nettype none
module lci_div import lci_pkg::*; #(
  parameter int unsigned NumW = DEN_W + FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [1:0][NumW-1:0]  num_i,
  input  logic [1:0][DEN_W-1:0] den_i,
  output logic                  valid_o,
  output logic [1:0][Q_W-1:0]   quo_o
);

  localparam int unsigned HiW  = NumW - Q_W;
  localparam int unsigned CmpW = (HiW > DEN_W) ? HiW : DEN_W;
  localparam logic [Q_W-1:0] QMax = Q_W'(1) << (Q_W - 1);

  logic [DIV_STAGES-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DIV_STAGES-2:0], valid_i};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic             sat_e_q;
    logic [DEN_W-1:0] rem_e_q;
    logic [Q_W-1:0]   lo_e_q;
    logic [DEN_W-1:0] den_e_q;
    logic [HiW-1:0]   hi;
    logic             sat_q [Q_W];
    logic [DEN_W-1:0] rem_q [Q_W];
    logic [Q_W-1:0]   lo_q  [Q_W];
    logic [DEN_W-1:0] den_q [Q_W];
    logic [Q_W-1:0]   q_q   [Q_W];

    assign hi = num_i[l][NumW-1:Q_W];

    always_ff @(posedge clk_i) begin
      sat_e_q <= CmpW'(hi) >= CmpW'(den_i[l]);
      rem_e_q <= DEN_W'(hi);
      lo_e_q  <= num_i[l][Q_W-1:0];
      den_e_q <= den_i[l];
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic             sat_in;
      logic [DEN_W-1:0] rem_in;
      logic [Q_W-1:0]   lo_in;
      logic [DEN_W-1:0] den_in;
      logic [Q_W-1:0]   q_in;
      logic [DEN_W:0]   rem2;
      logic [DEN_W:0]   dif;
      logic             ge;
      if (j == 0) begin : g_first
        assign sat_in = sat_e_q;
        assign rem_in = rem_e_q;
        assign lo_in  = lo_e_q;
        assign den_in = den_e_q;
        assign q_in   = '0;
      end else begin : g_next
        assign sat_in = sat_q[j-1];
        assign rem_in = rem_q[j-1];
        assign lo_in  = lo_q[j-1];
        assign den_in = den_q[j-1];
        assign q_in   = q_q[j-1];
      end
      assign rem2 = {rem_in, lo_in[Q_W-1-j]};
      assign dif  = rem2 - {1'b0, den_in};
      assign ge   = rem2 >= {1'b0, den_in};
      always_ff @(posedge clk_i) begin
        sat_q[j] <= sat_in;
        lo_q[j]  <= lo_in;
        den_q[j] <= den_in;
        rem_q[j] <= ge ? dif[DEN_W-1:0] : rem2[DEN_W-1:0];
        q_q[j]   <= {q_in[Q_W-2:0], ge};
      end
    end

    assign quo_o[l] = (sat_q[Q_W-1] || (q_q[Q_W-1] > QMax)) ? QMax : q_q[Q_W-1];
  end

  assign valid_o = v_q[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: sv/line_cylinder_intersection.sv
`default_nettype none
`include "assert_macros.svh"
// Intersects one straight track with a z-aligned cylinder per request. A request is
// taken on every clock with start_i high and busy_o low, and busy_o is high only
// while reset is applied and up to the first clock edge after it, so one track per
// cycle is sustained. Each result appears on res_o for one cycle with done_o high; the
// receiver cannot stall it. The pipeline is built around the 64-stage square root of
// the 128-bit discriminant and the 64-stage root divider; the rest is nine front
// stages (rotation, products, discriminant) and seven back stages (root choice, hit
// point). Configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i;
// cfg_ready_o is low while busy_o is high, while any request is in flight and while
// start_i is high.
module line_cylinder_intersection import lci_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  req_t                  req_i,
  output logic                  done_o,
  output res_t                  res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NumW    = DEN_W + FracBits;
  localparam int unsigned Latency = 9 + SQRT_STAGES + 1 + DIV_STAGES + 6;

  typedef struct packed {
    req_t        req;
    logic        lin;
    logic        lin_ok;
    logic        ok;
    logic        hneg;
    logic        cneg;
    logic [63:0] hmag;
    logic [63:0] cmag;
    logic [63:0] a;
  } sd_t;

  typedef struct packed {
    req_t req;
    logic lin;
    logic hit;
    logic neg1;
    logic neg2;
  } ds_t;

  function automatic logic signed [31:0] sat_rot(input logic signed [51:0] v);
    logic signed [51:0] sh;
    sh = v >>> ROT_BITS;
    if (sh > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (sh < -52'sd2147483647) begin
      return -32'sd2147483647;
    end else begin
      return sh[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic               busy_q;
  logic [7:0]         inflight_q;
  logic signed [17:0] cos_q;
  logic signed [17:0] sin_q;
  logic signed [31:0] cx_q;
  logic signed [31:0] cy_q;
  logic signed [31:0] cz_q;
  logic [30:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 8'(start_i && !busy_q) - 8'(done_o);
    end
  end

  assign busy_o      = busy_q;
  assign cfg_ready_o = !busy_q && !start_i && (inflight_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= 18'sd65536;
      sin_q <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COS_ROT:  cos_q <= cfg_data_i[17:0];
        CFG_SIN_ROT:  sin_q <= cfg_data_i[17:0];
        CFG_CENTER_X: cx_q  <= cfg_data_i;
        CFG_CENTER_Y: cy_q  <= cfg_data_i;
        CFG_CENTER_Z: cz_q  <= cfg_data_i;
        CFG_RADIUS:   rad_q <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  logic [8:0] pv_q;
  logic [5:0] po_v_q;
  logic       s74_v_q;
  logic       sqrt_v;
  logic       div_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      s74_v_q <= 1'b0;
      po_v_q  <= '0;
    end else begin
      pv_q    <= {pv_q[7:0], start_i && !busy_q};
      s74_v_q <= sqrt_v;
      po_v_q  <= {po_v_q[4:0], div_v};
    end
  end

  // Front stages: frame change, squares and the discriminant.
  req_t               s1_req_q;
  logic signed [32:0] s1_dx_q;
  logic signed [32:0] s1_dy_q;
  logic signed [32:0] s1_kx;
  logic signed [32:0] s1_ky;
  req_t               s2_req_q;
  logic signed [50:0] s2_cdx_q, s2_sdy_q, s2_cdy_q, s2_sdx_q;
  logic signed [50:0] s2_ckx_q, s2_sky_q, s2_cky_q, s2_skx_q;
  req_t               s3_req_q;
  logic signed [31:0] s3_lbx_q, s3_lby_q, s3_lkx_q, s3_lky_q;
  req_t               s4_req_q;
  logic signed [63:0] s4_kx2_q, s4_ky2_q, s4_hx_q, s4_hy_q, s4_bx2_q, s4_by2_q;
  logic [61:0]        s4_r2_q;
  req_t               s5_req_q;
  logic [63:0]        s5_a_q;
  logic signed [64:0] s5_h_q;
  logic [63:0]        s5_sq_q;
  logic [61:0]        s5_r2_q;
  req_t               s6_req_q;
  logic               s6_lin_q;
  logic               s6_hneg_q;
  logic               s6_cneg_q;
  logic [63:0]        s6_hmag_q;
  logic [63:0]        s6_cmag_q;
  logic [63:0]        s6_a_q;
  sd_t                s7_sd_q;
  logic [63:0]        s7_hh_q, s7_hl_q, s7_ll_q;
  logic [63:0]        s7_ahch_q, s7_ahcl_q, s7_alch_q, s7_alcl_q;
  sd_t                s8_sd_q;
  logic [127:0]       s8_h2_q;
  logic [127:0]       s8_ac_q;
  sd_t                s9_sd_d;
  sd_t                s9_sd_q;
  logic [127:0]       s9_disc_q;

  assign s1_kx = 33'(s1_req_q.slope_x);
  assign s1_ky = 33'(s1_req_q.slope_y);

  always_comb begin
    s9_sd_d    = s8_sd_q;
    s9_sd_d.ok = s8_sd_q.cneg || (s8_h2_q >= s8_ac_q);
  end

  always_ff @(posedge clk_i) begin
    s1_req_q <= req_i;
    s1_dx_q  <= 33'(req_i.offset_x) - 33'(cx_q);
    s1_dy_q  <= 33'(req_i.offset_y) - 33'(cy_q);

    s2_req_q <= s1_req_q;
    s2_cdx_q <= cos_q * s1_dx_q;
    s2_sdy_q <= sin_q * s1_dy_q;
    s2_cdy_q <= cos_q * s1_dy_q;
    s2_sdx_q <= sin_q * s1_dx_q;
    s2_ckx_q <= cos_q * s1_kx;
    s2_sky_q <= sin_q * s1_ky;
    s2_cky_q <= cos_q * s1_ky;
    s2_skx_q <= sin_q * s1_kx;

    s3_req_q <= s2_req_q;
    s3_lbx_q <= sat_rot(52'(s2_cdx_q) + 52'(s2_sdy_q));
    s3_lby_q <= sat_rot(52'(s2_cdy_q) - 52'(s2_sdx_q));
    s3_lkx_q <= sat_rot(52'(s2_ckx_q) + 52'(s2_sky_q));
    s3_lky_q <= sat_rot(52'(s2_cky_q) - 52'(s2_skx_q));

    s4_req_q <= s3_req_q;
    s4_kx2_q <= s3_lkx_q * s3_lkx_q;
    s4_ky2_q <= s3_lky_q * s3_lky_q;
    s4_hx_q  <= s3_lkx_q * s3_lbx_q;
    s4_hy_q  <= s3_lky_q * s3_lby_q;
    s4_bx2_q <= s3_lbx_q * s3_lbx_q;
    s4_by2_q <= s3_lby_q * s3_lby_q;
    s4_r2_q  <= rad_q * rad_q;

    s5_req_q <= s4_req_q;
    s5_a_q   <= $unsigned(s4_kx2_q) + $unsigned(s4_ky2_q);
    s5_h_q   <= 65'(s4_hx_q) + 65'(s4_hy_q);
    s5_sq_q  <= $unsigned(s4_bx2_q) + $unsigned(s4_by2_q);
    s5_r2_q  <= s4_r2_q;

    s6_req_q  <= s5_req_q;
    s6_lin_q  <= s5_a_q < (64'(1) << FracBits);
    s6_hneg_q <= s5_h_q[64];
    s6_hmag_q <= s5_h_q[64] ? 64'(-s5_h_q) : s5_h_q[63:0];
    s6_cneg_q <= s5_sq_q < 64'(s5_r2_q);
    s6_cmag_q <= (s5_sq_q < 64'(s5_r2_q)) ? 64'(s5_r2_q) - s5_sq_q
                                          : s5_sq_q - 64'(s5_r2_q);
    s6_a_q    <= s5_a_q;

    s7_sd_q.req    <= s6_req_q;
    s7_sd_q.lin    <= s6_lin_q;
    s7_sd_q.lin_ok <= {s6_hmag_q, 1'b0} >= (65'(1) << FracBits);
    s7_sd_q.ok     <= 1'b0;
    s7_sd_q.hneg   <= s6_hneg_q;
    s7_sd_q.cneg   <= s6_cneg_q;
    s7_sd_q.hmag   <= s6_hmag_q;
    s7_sd_q.cmag   <= s6_cmag_q;
    s7_sd_q.a      <= s6_a_q;
    s7_hh_q   <= s6_hmag_q[63:32] * s6_hmag_q[63:32];
    s7_hl_q   <= s6_hmag_q[63:32] * s6_hmag_q[31:0];
    s7_ll_q   <= s6_hmag_q[31:0] * s6_hmag_q[31:0];
    s7_ahch_q <= s6_a_q[63:32] * s6_cmag_q[63:32];
    s7_ahcl_q <= s6_a_q[63:32] * s6_cmag_q[31:0];
    s7_alch_q <= s6_a_q[31:0] * s6_cmag_q[63:32];
    s7_alcl_q <= s6_a_q[31:0] * s6_cmag_q[31:0];

    s8_sd_q <= s7_sd_q;
    s8_h2_q <= {s7_hh_q, 64'd0} + (128'(s7_hl_q) << 33) + 128'(s7_ll_q);
    s8_ac_q <= {s7_ahch_q, 64'd0} + (128'(s7_ahcl_q) << 32) + (128'(s7_alch_q) << 32)
             + 128'(s7_alcl_q);

    s9_sd_q    <= s9_sd_d;
    s9_disc_q  <= s8_sd_q.cneg ? s8_h2_q + s8_ac_q : s8_h2_q - s8_ac_q;
  end

  logic [RT_W-1:0] root;
  sd_t             sd_line_q [SQRT_STAGES];

  lci_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pv_q[8]),
    .x_i     (s9_disc_q),
    .valid_o (sqrt_v),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    sd_line_q[0] <= s9_sd_q;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      sd_line_q[i] <= sd_line_q[i-1];
    end
  end

  // Root numerators and divider operands.
  sd_t                  sl;
  logic [64:0]          rsum;
  logic [63:0]          rdif;
  logic                 rge;
  logic [64:0]          mag1, mag2;
  logic                 neg1, neg2;
  logic [1:0][NumW-1:0]  s74_num_q;
  logic [1:0][DEN_W-1:0] s74_den_q;
  ds_t                  s74_ds_q;

  assign sl   = sd_line_q[SQRT_STAGES-1];
  assign rsum = {1'b0, sl.hmag} + {1'b0, root};
  assign rge  = sl.hmag >= root;
  assign rdif = rge ? sl.hmag - root : root - sl.hmag;

  always_comb begin
    if (sl.lin) begin
      mag1 = 65'(sl.cmag);
      neg1 = sl.cneg == sl.hneg;
    end else if (sl.hneg) begin
      mag1 = rsum;
      neg1 = 1'b0;
    end else begin
      mag1 = 65'(rdif);
      neg1 = rge;
    end
    if (!sl.hneg) begin
      mag2 = rsum;
      neg2 = 1'b1;
    end else begin
      mag2 = 65'(rdif);
      neg2 = !rge;
    end
  end

  always_ff @(posedge clk_i) begin
    s74_num_q[0] <= NumW'(mag1) << FracBits;
    s74_num_q[1] <= NumW'(mag2) << FracBits;
    s74_den_q[0] <= sl.lin ? {sl.hmag, 1'b0} : 65'(sl.a);
    s74_den_q[1] <= 65'(sl.a);
    s74_ds_q.req  <= sl.req;
    s74_ds_q.lin  <= sl.lin;
    s74_ds_q.hit  <= sl.lin ? sl.lin_ok : sl.ok;
    s74_ds_q.neg1 <= neg1;
    s74_ds_q.neg2 <= neg2;
  end

  logic [1:0][Q_W-1:0] quo;
  ds_t                 ds_line_q [DIV_STAGES];

  lci_div #(
    .NumW (NumW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s74_v_q),
    .num_i   (s74_num_q),
    .den_i   (s74_den_q),
    .valid_o (div_v),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    ds_line_q[0] <= s74_ds_q;
    for (int i = 1; i < DIV_STAGES; i++) begin
      ds_line_q[i] <= ds_line_q[i-1];
    end
  end

  // Back stages: signed roots, nearest to the center, hit point.
  ds_t                p1_ds_q, p2_ds_q, p3_ds_q;
  logic signed [63:0] p1_z1_q, p1_z2_q, p2_z1_q, p2_z2_q, p3_z1_q, p3_z2_q;
  logic signed [64:0] p2_e1_q, p2_e2_q;
  logic [64:0]        p3_a1_q, p3_a2_q;
  logic signed [63:0] zsel;
  req_t               p4_req_q;
  logic               p4_hit_q;
  logic signed [31:0] p4_zo_q;
  req_t               p5_req_q;
  logic               p5_hit_q;
  logic signed [31:0] p5_zo_q;
  logic signed [63:0] p5_px_q, p5_py_q;
  res_t               res_q;

  assign zsel = (!p3_ds_q.lin && (p3_a2_q < p3_a1_q)) ? p3_z2_q : p3_z1_q;

  always_ff @(posedge clk_i) begin
    p1_ds_q <= ds_line_q[DIV_STAGES-1];
    p1_z1_q <= ds_line_q[DIV_STAGES-1].neg1 ? -$signed(64'(quo[0])) : $signed(64'(quo[0]));
    p1_z2_q <= ds_line_q[DIV_STAGES-1].neg2 ? -$signed(64'(quo[1])) : $signed(64'(quo[1]));

    p2_ds_q <= p1_ds_q;
    p2_z1_q <= p1_z1_q;
    p2_z2_q <= p1_z2_q;
    p2_e1_q <= 65'(p1_z1_q) - 65'(cz_q);
    p2_e2_q <= 65'(p1_z2_q) - 65'(cz_q);

    p3_ds_q <= p2_ds_q;
    p3_z1_q <= p2_z1_q;
    p3_z2_q <= p2_z2_q;
    p3_a1_q <= p2_e1_q[64] ? 65'(-p2_e1_q) : 65'(p2_e1_q);
    p3_a2_q <= p2_e2_q[64] ? 65'(-p2_e2_q) : 65'(p2_e2_q);

    p4_req_q <= p3_ds_q.req;
    p4_hit_q <= p3_ds_q.hit;
    p4_zo_q  <= p3_ds_q.hit ? sat32(65'(zsel)) : '0;

    p5_req_q <= p4_req_q;
    p5_hit_q <= p4_hit_q;
    p5_zo_q  <= p4_zo_q;
    p5_px_q  <= p4_req_q.slope_x * p4_zo_q;
    p5_py_q  <= p4_req_q.slope_y * p4_zo_q;

    res_q.hit_valid <= p5_hit_q;
    res_q.hit_z     <= p5_zo_q;
    res_q.hit_x     <= p5_hit_q ? sat32(65'(p5_px_q >>> FracBits) + 65'(p5_req_q.offset_x))
                                : '0;
    res_q.hit_y     <= p5_hit_q ? sat32(65'(p5_py_q >>> FracBits) + 65'(p5_req_q.offset_y))
                                : '0;
  end

  assign done_o = po_v_q[5];
  assign res_o  = res_q;

  `LCI_ASSERT(a_fixed_latency, (start_i && !busy_o) |-> ##Latency done_o, clk_i, rst_ni)
  `LCI_ASSERT(a_done_has_request, done_o |-> $past(start_i && !busy_o, Latency), clk_i, rst_ni)
  `LCI_ASSERT(a_miss_is_zero, (done_o && !res_o.hit_valid) |-> (res_o == '0), clk_i, rst_ni)
  `LCI_ASSERT_NR(a_cfg_only_idle, cfg_ready_o |-> !busy_o, clk_i)

endmodule
`default_nettype wire
